@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define UG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("assertion failed");
`define UG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("implication failed");
`else
`define UG_ASSERT(label, prop)
`define UG_ASSERT_IMP(label, ante, cons)
`endif
`endif

@@ design/ugns_pkg.sv @@
// Types and constants of the grid neighbor search.
`default_nettype none
package ugns_pkg;
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	localparam logic [1:0] REG_CELL_SIZE   = 2'd0;
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;
	localparam logic [1:0] REG_GRID_DEPTH  = 2'd3;

	localparam int POS_W = 16;
	localparam int SIZE_W = 15;
	localparam int DIM_W = 7;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_P_RD,
		S_P_DIVGO,
		S_P_DIV,
		S_P_CELL,
		S_P_TRD,
		S_P_TWR,
		S_PRE_RD,
		S_PRE_WR,
		S_Q_DIV,
		S_Q_CELL,
		S_Q_TRD,
		S_Q_TWAIT,
		S_Q_MEM,
		S_Q_PIDX,
		S_Q_POS,
		S_Q_CMP,
		S_Q_NEXT,
		S_Q_FIN
	} state_t;
endpackage
`default_nettype wire

@@ design/ugns_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ugns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ design/ugns_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module ugns_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               go,
	input  wire logic signed [ugns_pkg::POS_W-1:0]  dividend,
	input  wire logic [ugns_pkg::SIZE_W-1:0]        divisor,
	output logic signed [ugns_pkg::POS_W-1:0]       quotient,
	output logic                                    done
);
	import ugns_pkg::*;

	logic                busy_q;
	logic [3:0]          cnt_q;
	logic                neg_q;
	logic [SIZE_W-1:0]   dv_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [POS_W-1:0]    mag_q;
	logic [POS_W-1:0]    trial;
	logic                ge;
	logic [POS_W-1:0]    diff;
	logic [POS_W-1:0]    mag_n;

	always_comb begin
		trial = {rem_q, mag_q[POS_W-1]};
		ge = trial >= {1'b0, dv_q};
		diff = trial - {1'b0, dv_q};
		mag_n = {mag_q[POS_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			neg_q <= dividend[POS_W-1];
			mag_q <= dividend[POS_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dv_q <= (divisor == '0) ? SIZE_W'(1) : divisor;
		end else if (busy_q) begin
			mag_q <= mag_n;
			rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
			if (cnt_q == 4'd15) begin
				quotient <= neg_q ? (~mag_n + 1'b1) : mag_n;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/uniform_grid_neighbor_search.sv @@
// Top level of the uniform grid neighbor search.
// Load and clear: one result, strobed in the cycle after the accepting edge; busy stays low.
// Build: clears the tally RAM, counts each stored particle into its cell after dividing its
// coordinates, sweeps the tallies into cell offsets, then a second pass writes the sorted
// indices; query: visits the 27 cells around the query point, one RAM read at a time.
// Reset clears control state; the receiver cannot stall, one result per strobe.
`default_nettype none
`include "assert_macros.svh"
module uniform_grid_neighbor_search #(
	parameter int PART_DEPTH = 256,
	parameter int MAX_CELLS = 512,
	parameter int MAX_HITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [1:0]                         operation,
	input  wire logic signed [ugns_pkg::POS_W-1:0]  pos_x,
	input  wire logic signed [ugns_pkg::POS_W-1:0]  pos_y,
	input  wire logic signed [ugns_pkg::POS_W-1:0]  pos_z,
	input  wire logic [ugns_pkg::SIZE_W-1:0]        radius,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [1:0]                         cfg_index,
	input  wire logic [ugns_pkg::SIZE_W-1:0]        cfg_data,
	output logic                                    strobe,
	output logic [7:0]                              neighbor_index,
	output logic                                    found,
	output logic                                    last,
	output logic [1:0]                              status
);
	import ugns_pkg::*;

	localparam int PART_AW = $clog2(PART_DEPTH);
	localparam int CNT_W = $clog2(PART_DEPTH + 1);
	localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int HIT_W = $clog2(MAX_HITS + 1);
	localparam int LIN_W = 21;
	localparam int G_W = POS_W + 2;
	localparam int SQ_W = 2 * POS_W + 1;

	state_t state_q, state_d;

	logic [SIZE_W-1:0] cell_size_q;
	logic [DIM_W-1:0]  grid_w_q, grid_h_q, grid_d_q;
	logic [13:0]       wh_q;

	logic [CNT_W-1:0]   total_q, i_q, run_q, slot_q, end_q;
	logic               built_q, pass2_q;
	logic [CELL_AW-1:0] cidx_q, cell_idx_q;
	logic               cell_ok_q;
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [SIZE_W-1:0]  radius_q;
	logic [2*SIZE_W-1:0] rsq_q;
	logic signed [1:0]  dx_q, dy_q, dz_q;
	logic [PART_AW-1:0] pidx_q, pend_idx_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q, sqz_q;
	logic [HIT_W-1:0]   hits_q;
	logic               pend_q;

	logic               acc;
	logic               emit, e_found, e_last;
	logic [PART_AW-1:0] e_idx;
	logic [1:0]         e_status;

	logic               st_we;
	logic [PART_AW-1:0] st_waddr, st_raddr;
	logic [3*POS_W-1:0] st_wdata, st_rdata;
	logic               ta_we;
	logic [CELL_AW-1:0] ta_waddr, ta_raddr;
	logic [CNT_W-1:0]   ta_wdata, ta_rdata;
	logic               of_we;
	logic [CNT_W-1:0]   of_rdata;
	logic               so_we;
	logic [PART_AW-1:0] so_waddr, so_wdata, so_raddr, so_rdata;

	logic               div_go, div_done, div_dy, div_dz;
	logic signed [POS_W-1:0] div_ax, div_ay, div_az, qx, qy, qz;

	logic signed [G_W-1:0] gx, gy, gz;
	logic signed [1:0]  ax, ay, az;
	logic               in_x, in_y, in_z;
	logic [LIN_W-1:0]   lin;
	logic               cell_ok;

	logic signed [POS_W:0]   ex, ey, ez;
	logic signed [SQ_W:0]    ex2, ey2, ez2;
	logic [SQ_W+1:0]         dist_sq;
	logic                    hit;

	assign busy = (state_q != S_IDLE);
	assign acc = start && !busy;
	assign cfg_ready = 1'b1;

	ugns_ram #(.WIDTH(3 * POS_W), .DEPTH(PART_DEPTH)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);
	ugns_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_tally (
		.clk(clk), .we(ta_we), .waddr(ta_waddr), .wdata(ta_wdata),
		.raddr(ta_raddr), .rdata(ta_rdata)
	);
	ugns_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CELLS)) u_offset (
		.clk(clk), .we(of_we), .waddr(cidx_q), .wdata(run_q),
		.raddr(cell_idx_q), .rdata(of_rdata)
	);
	ugns_ram #(.WIDTH(PART_AW), .DEPTH(PART_DEPTH)) u_sorted (
		.clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
		.raddr(so_raddr), .rdata(so_rdata)
	);

	assign div_ax = (state_q == S_IDLE) ? pos_x : st_rdata[POS_W-1:0];
	assign div_ay = (state_q == S_IDLE) ? pos_y : st_rdata[2*POS_W-1:POS_W];
	assign div_az = (state_q == S_IDLE) ? pos_z : st_rdata[3*POS_W-1:2*POS_W];

	ugns_div u_div_x (.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_ax),
		.divisor(cell_size_q), .quotient(qx), .done(div_done));
	ugns_div u_div_y (.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_ay),
		.divisor(cell_size_q), .quotient(qy), .done(div_dy));
	ugns_div u_div_z (.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_az),
		.divisor(cell_size_q), .quotient(qz), .done(div_dz));

	// Cell of the current coordinates, shifted by the neighbor offset in a query.
	always_comb begin
		ax = (state_q == S_Q_CELL) ? dx_q : 2'sd0;
		ay = (state_q == S_Q_CELL) ? dy_q : 2'sd0;
		az = (state_q == S_Q_CELL) ? dz_q : 2'sd0;
		gx = G_W'(qx) + G_W'(ax);
		gy = G_W'(qy) + G_W'(ay);
		gz = G_W'(qz) + G_W'(az);
		in_x = !gx[G_W-1] && ($unsigned(gx) < G_W'(grid_w_q));
		in_y = !gy[G_W-1] && ($unsigned(gy) < G_W'(grid_h_q));
		in_z = !gz[G_W-1] && ($unsigned(gz) < G_W'(grid_d_q));
		lin = LIN_W'(gx[DIM_W-1:0]) + LIN_W'(gy[DIM_W-1:0]) * LIN_W'(grid_w_q)
			+ LIN_W'(gz[DIM_W-1:0]) * LIN_W'(wh_q);
		cell_ok = in_x && in_y && in_z && (lin < LIN_W'(MAX_CELLS));
	end

	always_comb begin
		ex = (POS_W+1)'(px_q) - (POS_W+1)'($signed(st_rdata[POS_W-1:0]));
		ey = (POS_W+1)'(py_q) - (POS_W+1)'($signed(st_rdata[2*POS_W-1:POS_W]));
		ez = (POS_W+1)'(pz_q) - (POS_W+1)'($signed(st_rdata[3*POS_W-1:2*POS_W]));
		ex2 = ex * ex;
		ey2 = ey * ey;
		ez2 = ez * ez;
		dist_sq = (SQ_W+2)'(sqx_q) + (SQ_W+2)'(sqy_q) + (SQ_W+2)'(sqz_q);
		hit = dist_sq < (SQ_W+2)'(rsq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go = 1'b0;
		st_we = 1'b0;
		st_waddr = total_q[PART_AW-1:0];
		st_wdata = {pos_z, pos_y, pos_x};
		st_raddr = i_q[PART_AW-1:0];
		ta_we = 1'b0;
		ta_waddr = cell_idx_q;
		ta_wdata = ta_rdata + 1'b1;
		ta_raddr = cell_idx_q;
		of_we = 1'b0;
		so_we = 1'b0;
		so_waddr = ta_rdata[PART_AW-1:0];
		so_wdata = i_q[PART_AW-1:0];
		so_raddr = slot_q[PART_AW-1:0];
		emit = 1'b0;
		e_idx = '0;
		e_found = 1'b0;
		e_last = 1'b1;
		e_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (operation)
						OP_LOAD: begin
							emit = 1'b1;
							if (total_q < CNT_W'(PART_DEPTH)) begin
								st_we = 1'b1;
							end else begin
								e_status = ST_FULL;
							end
						end
						OP_BUILD: state_d = S_CLR;
						OP_QUERY: begin
							div_go = 1'b1;
							state_d = S_Q_DIV;
						end
						OP_CLEAR: emit = 1'b1;
						default: ;
					endcase
				end
			end
			S_CLR: begin
				ta_we = 1'b1;
				ta_waddr = cidx_q;
				ta_wdata = '0;
				if (cidx_q == CELL_AW'(MAX_CELLS - 1)) begin
					state_d = S_P_RD;
				end
			end
			S_P_RD: begin
				if (i_q == total_q) begin
					if (pass2_q) begin
						emit = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_PRE_RD;
					end
				end else begin
					state_d = S_P_DIVGO;
				end
			end
			S_P_DIVGO: begin
				div_go = 1'b1;
				state_d = S_P_DIV;
			end
			S_P_DIV: begin
				if (div_done) begin
					state_d = S_P_CELL;
				end
			end
			S_P_CELL: state_d = S_P_TRD;
			S_P_TRD: state_d = cell_ok_q ? S_P_TWR : S_P_RD;
			S_P_TWR: begin
				ta_we = 1'b1;
				so_we = pass2_q;
				state_d = S_P_RD;
			end
			S_PRE_RD: begin
				ta_raddr = cidx_q;
				state_d = S_PRE_WR;
			end
			S_PRE_WR: begin
				ta_we = 1'b1;
				ta_waddr = cidx_q;
				ta_wdata = run_q;
				of_we = 1'b1;
				state_d = (cidx_q == CELL_AW'(MAX_CELLS - 1)) ? S_P_RD : S_PRE_RD;
			end
			S_Q_DIV: begin
				if (div_done) begin
					state_d = S_Q_CELL;
				end
			end
			S_Q_CELL: state_d = S_Q_TRD;
			S_Q_TRD: state_d = (cell_ok_q && built_q) ? S_Q_TWAIT : S_Q_NEXT;
			S_Q_TWAIT: state_d = S_Q_MEM;
			S_Q_MEM: state_d = (slot_q < end_q) ? S_Q_PIDX : S_Q_NEXT;
			S_Q_PIDX: begin
				st_raddr = so_rdata;
				state_d = S_Q_POS;
			end
			S_Q_POS: state_d = S_Q_CMP;
			S_Q_CMP: begin
				if (hit && pend_q) begin
					emit = 1'b1;
					e_idx = pend_idx_q;
					e_found = 1'b1;
					e_last = 1'b0;
				end
				if (hit && (hits_q == HIT_W'(MAX_HITS - 1))) begin
					state_d = S_Q_FIN;
				end else begin
					state_d = S_Q_MEM;
				end
			end
			S_Q_NEXT: begin
				if (dx_q == 2'sd1 && dy_q == 2'sd1 && dz_q == 2'sd1) begin
					state_d = S_Q_FIN;
				end else begin
					state_d = S_Q_CELL;
				end
			end
			S_Q_FIN: begin
				emit = 1'b1;
				if (pend_q) begin
					e_idx = pend_idx_q;
					e_found = 1'b1;
					if (hits_q == HIT_W'(MAX_HITS)) begin
						e_status = ST_LIMIT;
					end
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= SIZE_W'(16);
			grid_w_q <= DIM_W'(8);
			grid_h_q <= DIM_W'(8);
			grid_d_q <= DIM_W'(8);
			wh_q <= 14'd64;
			total_q <= '0;
			built_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			wh_q <= 14'(grid_w_q) * 14'(grid_h_q);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CELL_SIZE:   cell_size_q <= cfg_data;
					REG_GRID_WIDTH:  grid_w_q <= cfg_data[DIM_W-1:0];
					REG_GRID_HEIGHT: grid_h_q <= cfg_data[DIM_W-1:0];
					REG_GRID_DEPTH:  grid_d_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (st_we) begin
				total_q <= total_q + 1'b1;
			end else if (acc && operation == OP_CLEAR) begin
				total_q <= '0;
			end
			if (state_q == S_P_RD && i_q == total_q && pass2_q) begin
				built_q <= 1'b1;
			end
			strobe <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			neighbor_index <= 8'(e_idx);
			found <= e_found;
			last <= e_last;
			status <= e_status;
		end
		case (state_q)
			S_IDLE: begin
				px_q <= pos_x;
				py_q <= pos_y;
				pz_q <= pos_z;
				radius_q <= radius;
				dx_q <= -2'sd1;
				dy_q <= -2'sd1;
				dz_q <= -2'sd1;
				hits_q <= '0;
				pend_q <= 1'b0;
				cidx_q <= '0;
				i_q <= '0;
				run_q <= '0;
				pass2_q <= 1'b0;
			end
			S_CLR: begin
				cidx_q <= (cidx_q == CELL_AW'(MAX_CELLS - 1)) ? '0 : cidx_q + 1'b1;
			end
			S_P_CELL, S_Q_CELL: begin
				cell_idx_q <= lin[CELL_AW-1:0];
				cell_ok_q <= cell_ok;
			end
			S_P_TRD: begin
				if (!cell_ok_q) begin
					i_q <= i_q + 1'b1;
				end
			end
			S_P_TWR: i_q <= i_q + 1'b1;
			S_PRE_WR: begin
				run_q <= run_q + ta_rdata;
				if (cidx_q == CELL_AW'(MAX_CELLS - 1)) begin
					cidx_q <= '0;
					pass2_q <= 1'b1;
					i_q <= '0;
				end else begin
					cidx_q <= cidx_q + 1'b1;
				end
			end
			S_Q_DIV: rsq_q <= radius_q * radius_q;
			S_Q_TWAIT: begin
				slot_q <= of_rdata;
				end_q <= ta_rdata;
			end
			S_Q_PIDX: pidx_q <= so_rdata;
			S_Q_POS: begin
				sqx_q <= ex2[SQ_W-1:0];
				sqy_q <= ey2[SQ_W-1:0];
				sqz_q <= ez2[SQ_W-1:0];
			end
			S_Q_CMP: begin
				slot_q <= slot_q + 1'b1;
				if (hit) begin
					pend_q <= 1'b1;
					pend_idx_q <= pidx_q;
					hits_q <= hits_q + 1'b1;
				end
			end
			S_Q_NEXT: begin
				if (dx_q != 2'sd1) begin
					dx_q <= dx_q + 2'sd1;
				end else begin
					dx_q <= -2'sd1;
					if (dy_q != 2'sd1) begin
						dy_q <= dy_q + 2'sd1;
					end else begin
						dy_q <= -2'sd1;
						dz_q <= dz_q + 2'sd1;
					end
				end
			end
			default: ;
		endcase
	end

	`UG_ASSERT(a_total_max, total_q <= CNT_W'(PART_DEPTH))
	`UG_ASSERT(a_hits_max, hits_q <= HIT_W'(MAX_HITS) || state_q == S_IDLE)
	`UG_ASSERT_IMP(a_strobe_src, strobe, $past(busy || start))
	`UG_ASSERT_IMP(a_hit_status, strobe && found, status != ST_FULL)
	`UG_ASSERT_IMP(a_cell_after_div, state_q == S_P_CELL, $past(div_done))
endmodule
`default_nettype wire
